[hw/rtl/gsu_pkg.sv]
// Shared types, widths and vector arithmetic for the GJK simplex update pipeline.
// Used by gsu_front, gsu_tri, gjk_simplex_update and the testbench; depends on nothing else.
package gsu_pkg;

  localparam int COORD_BITS = 16;
  localparam int LANE = 16;
  localparam int PW = 3 * LANE;
  localparam int CW = 3;
  localparam int OW = 54;

  // Difference vectors and the negated newest point need one bit more than a coordinate.
  localparam int DW = COORD_BITS + 1;
  localparam int NW = 2 * DW + 1;
  localparam int MW = NW + DW + 1;
  localparam int DDW = 2 * DW + 2;
  localparam int NDW = NW + DW + 2;
  localparam int MDW = MW + DW + 2;

  typedef enum logic [1:0] {K_POINT, K_LINE, K_TRI, K_TETRA} kind_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } dvec_t;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
  } nvec_t;

  typedef struct packed {
    logic signed [MW-1:0] x;
    logic signed [MW-1:0] y;
    logic signed [MW-1:0] z;
  } mvec_t;

  typedef struct packed {
    kind_t kind;
    logic hit;
    logic [PW-1:0] sa;
    logic [PW-1:0] sb;
    logic [PW-1:0] sc;
    logic [PW-1:0] sd;
    dvec_t ao;
    dvec_t ab;
    dvec_t ac;
  } front_t;

  typedef struct packed {
    kind_t kind;
    logic hit;
    logic [PW-1:0] sa;
    logic [PW-1:0] sb;
    logic [PW-1:0] sc;
    logic [PW-1:0] sd;
    dvec_t ao;
    nvec_t abc;
    mvec_t tab;
    mvec_t tac;
    logic dab;
    logic dac;
    logic dabc;
    logic q1;
    logic q2;
  } tri_t;

  function automatic logic signed [DW-1:0] coord(logic [PW-1:0] p, int unsigned i);
    logic signed [COORD_BITS-1:0] c;
    c = $signed(p[LANE*i +: COORD_BITS]);
    return DW'(c);
  endfunction

  function automatic dvec_t sub_pt(logic [PW-1:0] p, logic [PW-1:0] q);
    dvec_t r;
    r.x = coord(p, 0) - coord(q, 0);
    r.y = coord(p, 1) - coord(q, 1);
    r.z = coord(p, 2) - coord(q, 2);
    return r;
  endfunction

  function automatic dvec_t neg_pt(logic [PW-1:0] p);
    dvec_t r;
    r.x = -coord(p, 0);
    r.y = -coord(p, 1);
    r.z = -coord(p, 2);
    return r;
  endfunction

  function automatic nvec_t cross_dd(dvec_t a, dvec_t b);
    nvec_t r;
    r.x = NW'(a.y) * NW'(b.z) - NW'(a.z) * NW'(b.y);
    r.y = NW'(a.z) * NW'(b.x) - NW'(a.x) * NW'(b.z);
    r.z = NW'(a.x) * NW'(b.y) - NW'(a.y) * NW'(b.x);
    return r;
  endfunction

  function automatic mvec_t cross_nd(nvec_t a, dvec_t b);
    mvec_t r;
    r.x = MW'(a.y) * MW'(b.z) - MW'(a.z) * MW'(b.y);
    r.y = MW'(a.z) * MW'(b.x) - MW'(a.x) * MW'(b.z);
    r.z = MW'(a.x) * MW'(b.y) - MW'(a.y) * MW'(b.x);
    return r;
  endfunction

  function automatic logic signed [DDW-1:0] dot_dd(dvec_t a, dvec_t b);
    return DDW'(a.x) * DDW'(b.x) + DDW'(a.y) * DDW'(b.y) + DDW'(a.z) * DDW'(b.z);
  endfunction

  function automatic logic signed [NDW-1:0] dot_nd(nvec_t a, dvec_t b);
    return NDW'(a.x) * NDW'(b.x) + NDW'(a.y) * NDW'(b.y) + NDW'(a.z) * NDW'(b.z);
  endfunction

  function automatic logic signed [MDW-1:0] dot_md(mvec_t a, dvec_t b);
    return MDW'(a.x) * MDW'(b.x) + MDW'(a.y) * MDW'(b.y) + MDW'(a.z) * MDW'(b.z);
  endfunction

endpackage

[hw/rtl/gsu_front.sv]
// Front half of the pipeline: input decode, edge vectors and the tetrahedron face tests.
// Picks the triangle that the back half works on. Depends on gsu_pkg.
module gsu_front
  import gsu_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [CW-1:0] point_count,
  input  logic [PW-1:0] point_a,
  input  logic [PW-1:0] point_b,
  input  logic [PW-1:0] point_c,
  input  logic [PW-1:0] point_d,
  output logic          out_valid,
  output front_t        out_data
);

  logic          v1, v2, v3, v4;
  kind_t         kind_in, k1, k2, k3, k4;
  logic [PW-1:0] a1, b1, c1, d1, a2, b2, c2, d2, a3, b3, c3, d3, a4, b4, c4, d4;
  dvec_t         ao2, ab2, ac2, ad2, ao3, ab3, ac3, ad3, ao4, ab4, ac4, ad4;
  nvec_t         n1, n2, n3;
  logic          s1, s2, s3;

  always_comb begin
    unique case (point_count) inside
      3'd0, 3'd1: kind_in = K_POINT;
      3'd2:       kind_in = K_LINE;
      3'd3:       kind_in = K_TRI;
      default:    kind_in = K_TETRA;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    k1 <= kind_in;
    a1 <= point_a;
    b1 <= point_b;
    c1 <= point_c;
    d1 <= point_d;

    k2 <= k1;
    a2 <= a1;
    b2 <= b1;
    c2 <= c1;
    d2 <= d1;
    ao2 <= neg_pt(a1);
    ab2 <= sub_pt(b1, a1);
    ac2 <= sub_pt(c1, a1);
    ad2 <= sub_pt(d1, a1);

    k3 <= k2;
    a3 <= a2;
    b3 <= b2;
    c3 <= c2;
    d3 <= d2;
    ao3 <= ao2;
    ab3 <= ab2;
    ac3 <= ac2;
    ad3 <= ad2;
    n1 <= cross_dd(ab2, ad2);
    n2 <= cross_dd(ac2, ab2);
    n3 <= cross_dd(ad2, ac2);

    k4 <= k3;
    a4 <= a3;
    b4 <= b3;
    c4 <= c3;
    d4 <= d3;
    ao4 <= ao3;
    ab4 <= ab3;
    ac4 <= ac3;
    ad4 <= ad3;
    s1 <= dot_nd(n1, ao3) < 0;
    s2 <= dot_nd(n2, ao3) < 0;
    s3 <= dot_nd(n3, ao3) >= 0;
  end

  // A tetrahedron keeps the face the origin is outside of as a triangle, or sets hit.
  always_comb begin
    out_valid = v4;
    out_data.kind = k4;
    out_data.hit = 1'b0;
    out_data.sa = a4;
    out_data.sb = b4;
    out_data.sc = c4;
    out_data.sd = d4;
    out_data.ao = ao4;
    out_data.ab = ab4;
    out_data.ac = ac4;
    if (k4 == K_TETRA) begin
      if (s1) begin
        out_data.sc = d4;
        out_data.ac = ad4;
      end else if (s2) begin
        out_data.hit = 1'b0;
      end else if (s3) begin
        out_data.hit = 1'b1;
      end else begin
        out_data.sb = c4;
        out_data.sc = d4;
        out_data.ab = ac4;
        out_data.ac = ad4;
      end
    end
  end

endmodule

[hw/rtl/gsu_tri.sv]
// Back half of the pipeline: triangle normal, edge directions and the region sign tests.
// Takes the triangle chosen by gsu_front. Depends on gsu_pkg.
module gsu_tri
  import gsu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  front_t in_data,
  output logic   out_valid,
  output tri_t   out_data
);

  logic   v1, v2, v3, v4;
  front_t f1, f2, f3;
  nvec_t  abc2, eab2, eac2, abc3;
  mvec_t  p1, p2, tab3, tac3;
  logic   dab3, dac3, dabc3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    f1 <= in_data;

    f2 <= f1;
    abc2 <= cross_dd(f1.ab, f1.ac);
    eab2 <= cross_dd(f1.ab, f1.ao);
    eac2 <= cross_dd(f1.ac, f1.ao);

    f3 <= f2;
    abc3 <= abc2;
    p1 <= cross_nd(abc2, f2.ac);
    p2 <= cross_nd(abc2, f2.ab);
    tab3 <= cross_nd(eab2, f2.ab);
    tac3 <= cross_nd(eac2, f2.ac);
    dab3 <= dot_dd(f2.ab, f2.ao) > 0;
    dac3 <= dot_dd(f2.ac, f2.ao) > 0;
    dabc3 <= dot_nd(abc2, f2.ao) > 0;

    out_data.kind <= f3.kind;
    out_data.hit <= f3.hit;
    out_data.sa <= f3.sa;
    out_data.sb <= f3.sb;
    out_data.sc <= f3.sc;
    out_data.sd <= f3.sd;
    out_data.ao <= f3.ao;
    out_data.abc <= abc3;
    out_data.tab <= tab3;
    out_data.tac <= tac3;
    out_data.dab <= dab3;
    out_data.dac <= dac3;
    out_data.dabc <= dabc3;
    // The region beyond edge AB tests (AB x ABC).AO > 0, that is (ABC x AB).AO < 0.
    out_data.q1 <= dot_md(p1, f3.ao) > 0;
    out_data.q2 <= dot_md(p2, f3.ao) < 0;
  end

  assign out_valid = v4;

endmodule

[hw/rtl/gjk_simplex_update.sv]
// GJK simplex update (3-D): point, line, triangle and tetrahedron region tests against the origin.
// Instantiates gsu_front and gsu_tri; depends on gsu_pkg.
//
// Usage:
//   Present point_count and point_a..point_d with start high; the transaction is
//   taken at any rising edge where start is high and busy is low. busy never rises,
//   so a new simplex may be issued in every cycle.
//   The result (new_count, out_a..out_d, dir_x/y/z, intersect_res) appears on the
//   result ports for exactly one cycle with done high. Results leave in the order
//   the transactions came in. Throughput is one transaction per cycle; each
//   transaction passes through nine register stages: input capture, edge vectors,
//   face normals, face sign tests, triangle selection, triangle normal, second
//   cross products, final dot-product signs and the output register.
//   The receiver cannot stall: every result must be taken in its done cycle.
//   A synchronous reset clears all valid bits, so no result comes out of a
//   transaction that was in flight during reset.
module gjk_simplex_update
  import gsu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [CW-1:0]        point_count,
  input  logic [PW-1:0]        point_a,
  input  logic [PW-1:0]        point_b,
  input  logic [PW-1:0]        point_c,
  input  logic [PW-1:0]        point_d,
  output logic                 done,
  output logic [CW-1:0]        new_count,
  output logic [PW-1:0]        out_a,
  output logic [PW-1:0]        out_b,
  output logic [PW-1:0]        out_c,
  output logic [PW-1:0]        out_d,
  output logic signed [OW-1:0] dir_x,
  output logic signed [OW-1:0] dir_y,
  output logic signed [OW-1:0] dir_z,
  output logic                 intersect_res
);

  logic                 fv, tv;
  front_t               fd;
  tri_t                 r;
  logic [CW-1:0]        count_next;
  logic [PW-1:0]        b_next, c_next;
  logic signed [OW-1:0] dx_next, dy_next, dz_next;

  assign busy = 1'b0;

  gsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start & ~busy),
    .point_count (point_count),
    .point_a     (point_a),
    .point_b     (point_b),
    .point_c     (point_c),
    .point_d     (point_d),
    .out_valid   (fv),
    .out_data    (fd)
  );

  gsu_tri u_tri (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv),
    .in_data   (fd),
    .out_valid (tv),
    .out_data  (r)
  );

  always_comb begin
    logic toward_ab;
    toward_ab = 1'b0;
    count_next = CW'(1);
    b_next = r.sb;
    c_next = r.sc;
    dx_next = OW'(r.ao.x);
    dy_next = OW'(r.ao.y);
    dz_next = OW'(r.ao.z);
    case (r.kind)
      K_POINT: toward_ab = 1'b0;
      K_LINE:  toward_ab = 1'b1;
      default: begin
        if (r.hit) begin
          count_next = CW'(4);
          dx_next = '0;
          dy_next = '0;
          dz_next = '0;
        end else if (r.q1 && r.dac) begin
          count_next = CW'(2);
          b_next = r.sc;
          dx_next = OW'(r.tac.x);
          dy_next = OW'(r.tac.y);
          dz_next = OW'(r.tac.z);
        end else if (r.q1 || r.q2) begin
          toward_ab = 1'b1;
        end else if (r.dabc) begin
          count_next = CW'(3);
          dx_next = OW'(r.abc.x);
          dy_next = OW'(r.abc.y);
          dz_next = OW'(r.abc.z);
        end else begin
          // Origin behind the triangle: flip the winding and the normal.
          count_next = CW'(3);
          b_next = r.sc;
          c_next = r.sb;
          dx_next = -OW'(r.abc.x);
          dy_next = -OW'(r.abc.y);
          dz_next = -OW'(r.abc.z);
        end
      end
    endcase
    if (toward_ab && r.dab) begin
      count_next = CW'(2);
      dx_next = OW'(r.tab.x);
      dy_next = OW'(r.tab.y);
      dz_next = OW'(r.tab.z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tv;
    end
  end

  always_ff @(posedge clk) begin
    new_count <= count_next;
    out_a <= r.sa;
    out_b <= b_next;
    out_c <= c_next;
    out_d <= r.sd;
    dir_x <= dx_next;
    dir_y <= dy_next;
    dir_z <= dz_next;
    intersect_res <= (r.kind == K_TETRA) && r.hit;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##9 done)
    else $error("result missing nine cycles after a transaction");

  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    done && intersect_res |-> new_count == CW'(4) && dir_x == '0 && dir_y == '0
      && dir_z == '0)
    else $error("intersection without count four and zero direction");

  a_count: assert property (@(posedge clk) disable iff (rst)
    done |-> new_count == CW'(1) || new_count == CW'(2) || new_count == CW'(3)
      || new_count == CW'(4))
    else $error("reduced simplex size out of range");

  a_point_slots: assert property (@(posedge clk) disable iff (rst)
    done && new_count == CW'(1) |-> !intersect_res)
    else $error("single-point result flagged as intersection");
`endif

endmodule

[test/gjk_simplex_update_tb.sv]
// Self-checking testbench for gjk_simplex_update: directed and random simplex updates.
// Predicts every result with its own exact-arithmetic region test; depends on gsu_pkg.
module gjk_simplex_update_tb;
  import gsu_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef struct {
    logic signed [63:0] x, y, z;
  } v3_t;

  typedef struct packed {
    logic [CW-1:0]        count;
    logic [PW-1:0]        a, b, c, d;
    logic signed [OW-1:0] dx, dy, dz;
    logic                 hit;
  } update_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CW-1:0]        point_count = '0;
  logic [PW-1:0]        point_a = '0, point_b = '0, point_c = '0, point_d = '0;
  logic                 done;
  logic [CW-1:0]        new_count;
  logic [PW-1:0]        out_a, out_b, out_c, out_d;
  logic signed [OW-1:0] dir_x, dir_y, dir_z;
  logic                 intersect_res;

  update_t expected_updates[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      gap_pct = 0;

  gjk_simplex_update u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("gjk_simplex_update: mismatch");
      $finish;
    end
  end

  function automatic v3_t unpack_pt(logic [PW-1:0] p);
    v3_t r;
    r.x = 64'($signed(p[COORD_BITS-1:0]));
    r.y = 64'($signed(p[LANE +: COORD_BITS]));
    r.z = 64'($signed(p[2*LANE +: COORD_BITS]));
    return r;
  endfunction

  function automatic v3_t vsub(v3_t a, v3_t b);
    v3_t r;
    r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
    return r;
  endfunction

  function automatic v3_t vneg(v3_t a);
    v3_t r;
    r.x = -a.x; r.y = -a.y; r.z = -a.z;
    return r;
  endfunction

  function automatic v3_t vcross(v3_t a, v3_t b);
    v3_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  function automatic int dot_sign(v3_t a, v3_t b);
    wide_t s;
    s = wide_t'(a.x) * wide_t'(b.x) + wide_t'(a.y) * wide_t'(b.y)
        + wide_t'(a.z) * wide_t'(b.z);
    return s < 0 ? -1 : (s == 0 ? 0 : 1);
  endfunction

  // Triangle region test on slots a, b, c; may drop or reorder slots.
  function automatic void triangle_region(ref update_t u, ref v3_t dv);
    v3_t a, ab, ac, ao, n;
    logic toward_ab;
    logic [PW-1:0] t;
    a = unpack_pt(u.a);
    ao = vneg(a);
    ab = vsub(unpack_pt(u.b), a);
    ac = vsub(unpack_pt(u.c), a);
    n = vcross(ab, ac);
    toward_ab = 1'b0;
    if (dot_sign(vcross(n, ac), ao) > 0) begin
      if (dot_sign(ac, ao) > 0) begin
        u.count = CW'(2);
        u.b = u.c;
        dv = vcross(vcross(ac, ao), ac);
        return;
      end
      toward_ab = 1'b1;
    end else if (dot_sign(vcross(ab, n), ao) > 0) begin
      toward_ab = 1'b1;
    end
    if (toward_ab) begin
      if (dot_sign(ab, ao) <= 0) begin
        u.count = CW'(1);
        dv = ao;
      end else begin
        u.count = CW'(2);
        dv = vcross(vcross(ab, ao), ab);
      end
      return;
    end
    u.count = CW'(3);
    if (dot_sign(n, ao) > 0) begin
      dv = n;
      return;
    end
    t = u.b; u.b = u.c; u.c = t;
    dv = vneg(n);
  endfunction

  function automatic update_t predict_update(logic [CW-1:0] n, logic [PW-1:0] pa,
                                             logic [PW-1:0] pb, logic [PW-1:0] pc,
                                             logic [PW-1:0] pd);
    update_t u;
    v3_t a, ao, ab, ac, ad, dv;
    u.a = pa; u.b = pb; u.c = pc; u.d = pd; u.hit = 1'b0;
    a = unpack_pt(pa);
    ao = vneg(a);
    ab = vsub(unpack_pt(pb), a);
    ac = vsub(unpack_pt(pc), a);
    ad = vsub(unpack_pt(pd), a);
    if (n <= 1) begin
      u.count = CW'(1);
      dv = ao;
    end else if (n == 2) begin
      if (dot_sign(ab, ao) > 0) begin
        u.count = CW'(2);
        dv = vcross(vcross(ab, ao), ab);
      end else begin
        u.count = CW'(1);
        dv = ao;
      end
    end else if (n == 3) begin
      triangle_region(u, dv);
    end else begin
      u.count = CW'(4);
      if (dot_sign(vcross(ab, ad), ao) < 0) begin
        u.c = u.d;
        triangle_region(u, dv);
      end else if (dot_sign(vcross(ac, ab), ao) < 0) begin
        triangle_region(u, dv);
      end else if (dot_sign(vcross(ad, ac), ao) >= 0) begin
        u.hit = 1'b1;
        dv.x = '0; dv.y = '0; dv.z = '0;
      end else begin
        u.b = u.c;
        u.c = u.d;
        triangle_region(u, dv);
      end
    end
    u.dx = dv.x[OW-1:0];
    u.dy = dv.y[OW-1:0];
    u.dz = dv.z[OW-1:0];
    return u;
  endfunction

  always @(posedge clk) begin
    update_t got, want;
    if (!rst && done) begin
      got = '{new_count, out_a, out_b, out_c, out_d, dir_x, dir_y, dir_z, intersect_res};
      if (expected_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_updates.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result differs: expected %p actual %p", want, got);
        end
      end
    end
  end

  // Sends one transaction, with a random idle gap before it.
  task automatic send_update(int n, logic [PW-1:0] pa, logic [PW-1:0] pb,
                             logic [PW-1:0] pc, logic [PW-1:0] pd);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    point_count <= CW'(n);
    point_a <= pa; point_b <= pb; point_c <= pc; point_d <= pd;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_updates.push_back(predict_update(CW'(n), pa, pb, pc, pd));
  endtask

  function automatic logic [PW-1:0] pack_pt(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [PW-1:0] rand_pt(int mag);
    logic [PW-1:0] p;
    p = PW'({$urandom, $urandom});
    if (mag > 0)
      p = pack_pt($urandom_range(2*mag) - mag, $urandom_range(2*mag) - mag,
                  $urandom_range(2*mag) - mag);
    return p;
  endfunction

  task automatic test_extremes;
    logic [PW-1:0] mx, mn;
    mx = pack_pt(32767, 32767, 32767);
    mn = pack_pt(-32768, -32768, -32768);
    for (int n = 0; n < 8; n++) send_update(n, mx, mn, mx, mn);
    send_update(4, mn, mx, pack_pt(32767, -32768, 0), pack_pt(-32768, 32767, 32767));
    send_update(2, '1, '0, '1, '0);
    send_update(3, '0, '1, '0, '1);
  endtask

  task automatic test_regions;
    // Tetrahedra with the origin outside and enclosed, triangles in both windings, degenerate triangles and lines.
    send_update(4, pack_pt(0, 0, 10), pack_pt(10, -10, -10), pack_pt(-10, -10, -10),
                pack_pt(0, 10, -10));
    send_update(4, pack_pt(0, 0, 10), pack_pt(0, 10, -10), pack_pt(-10, -10, -10),
                pack_pt(10, -10, -10));
    send_update(4, pack_pt(5, 5, 5), pack_pt(20, 5, 5), pack_pt(5, 20, 5), pack_pt(5, 5, 20));
    send_update(3, pack_pt(-5, 1, 1), pack_pt(5, 1, 1), pack_pt(0, 5, 1), '0);
    send_update(3, pack_pt(-5, 1, 1), pack_pt(0, 5, 1), pack_pt(5, 1, 1), '0);
    send_update(3, pack_pt(1, 1, 1), pack_pt(1, 1, 1), pack_pt(1, 1, 1), '0);
    send_update(3, pack_pt(10, 0, 0), pack_pt(20, 0, 0), pack_pt(30, 0, 0), '0);
    send_update(2, pack_pt(-3, 4, 0), pack_pt(3, 4, 0), '0, '0);
    send_update(2, pack_pt(3, 4, 0), pack_pt(6, 8, 0), '0, '0);
    send_update(2, '0, '0, '0, '0);
  endtask

  task automatic test_random(int items);
    int mag;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(3))
        0: mag = 0;
        1: mag = 40;
        2: mag = 2000;
        default: mag = 32767;
      endcase
      send_update($urandom_range(9) < 8 ? int'($urandom_range(4, 2)) : int'($urandom_range(7)),
                  rand_pt(mag), rand_pt(mag), rand_pt(mag), rand_pt(mag));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    gap_pct = 36;
    test_extremes();
    test_regions();
    test_random(700);
    gap_pct = 48;
    test_random(700);
    gap_pct = 0;
    test_random(600);
    start <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("gjk_simplex_update: match");
    else
      $display("gjk_simplex_update: mismatch");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/gsu_pkg.sv
hw/rtl/gsu_front.sv
hw/rtl/gsu_tri.sv
hw/rtl/gjk_simplex_update.sv
test/gjk_simplex_update_tb.sv
